FILE: design/srft_pkg.sv
// shared types, codes and helper functions for the step record field tokenizer
// no dependencies
package srft_pkg;

	localparam int MAX_DEPTH = 15;
	localparam int DEPTH_W = 4;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	// byte classes assigned by the front end
	localparam logic [3:0] CC_OTHER  = 4'd0;
	localparam logic [3:0] CC_SPACE  = 4'd1;
	localparam logic [3:0] CC_QUOTE  = 4'd2;
	localparam logic [3:0] CC_BSLASH = 4'd3;
	localparam logic [3:0] CC_LPAREN = 4'd4;
	localparam logic [3:0] CC_RPAREN = 4'd5;
	localparam logic [3:0] CC_COMMA  = 4'd6;
	localparam logic [3:0] CC_DIGIT  = 4'd7;
	localparam logic [3:0] CC_SIGN   = 4'd8;
	localparam logic [3:0] CC_DOLLAR = 4'd9;
	localparam logic [3:0] CC_HASH   = 4'd10;
	localparam logic [3:0] CC_DOT    = 4'd11;
	localparam logic [3:0] CC_NAME   = 4'd12;

	// element classifier states
	localparam logic [3:0] TC_EMPTY  = 4'd0;
	localparam logic [3:0] TC_DOLLAR = 4'd1;
	localparam logic [3:0] TC_SIGN   = 4'd2;
	localparam logic [3:0] TC_INT    = 4'd3;
	localparam logic [3:0] TC_HASH   = 4'd4;
	localparam logic [3:0] TC_REF    = 4'd5;
	localparam logic [3:0] TC_DOT    = 4'd6;
	localparam logic [3:0] TC_TRUE   = 4'd7;
	localparam logic [3:0] TC_FALSE  = 4'd8;
	localparam logic [3:0] TC_ENUM   = 4'd9;
	localparam logic [3:0] TC_STR    = 4'd10;
	localparam logic [3:0] TC_LIST   = 4'd11;
	localparam logic [3:0] TC_OTHER  = 4'd12;

	// reported element kinds
	localparam logic [3:0] K_UNSET = 4'd0;
	localparam logic [3:0] K_INT   = 4'd1;
	localparam logic [3:0] K_REF   = 4'd2;
	localparam logic [3:0] K_TRUE  = 4'd3;
	localparam logic [3:0] K_FALSE = 4'd4;
	localparam logic [3:0] K_ENUM  = 4'd5;
	localparam logic [3:0] K_STR   = 4'd6;
	localparam logic [3:0] K_LIST  = 4'd7;
	localparam logic [3:0] K_OTHER = 4'd8;

	// error codes, lower wins
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_ESCAPE   = 3'd1;
	localparam logic [2:0] ERR_PAREN    = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_OPEN_STR = 3'd4;

	localparam logic [31:0] ACC_LIMIT  = 32'h8000_0000;
	localparam logic [31:0] ACC_STICKY = 32'h8000_0001;
	localparam logic [31:0] POS_LIMIT  = 32'h7fff_ffff;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [3:0] cls;
	} srft_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic        ovf;
	} srft_fin_t;

	function automatic logic [3:0] kind_of(input logic [3:0] tc);
		logic [3:0] k;
		begin
			case (tc)
				TC_DOLLAR: k = K_UNSET;
				TC_INT:    k = K_INT;
				TC_REF:    k = K_REF;
				TC_TRUE:   k = K_TRUE;
				TC_FALSE:  k = K_FALSE;
				TC_ENUM:   k = K_ENUM;
				TC_STR:    k = K_STR;
				TC_LIST:   k = K_LIST;
				default:   k = K_OTHER;
			endcase
			return k;
		end
	endfunction

	function automatic logic [2:0] raise_err(input logic [2:0] cur, input logic [2:0] code);
		begin
			if (cur == ERR_NONE || code < cur)
				return code;
			return cur;
		end
	endfunction

endpackage

FILE: design/srft_front.sv
// front end: takes raw bytes, classifies them and hands them to the queue
// depends on srft_pkg
module srft_front import srft_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output srft_item_t push_item
);

	logic       valid_s1;
	srft_item_t item_s1;
	logic [3:0] cls;

	always_comb begin
		if (char_in == 8'h20 || char_in == 8'h09 || char_in == 8'h0d || char_in == 8'h0a)
			cls = CC_SPACE;
		else if (char_in == 8'h27)
			cls = CC_QUOTE;
		else if (char_in == 8'h5c)
			cls = CC_BSLASH;
		else if (char_in == 8'h28)
			cls = CC_LPAREN;
		else if (char_in == 8'h29)
			cls = CC_RPAREN;
		else if (char_in == 8'h2c)
			cls = CC_COMMA;
		else if (char_in >= 8'h30 && char_in <= 8'h39)
			cls = CC_DIGIT;
		else if (char_in == 8'h2b || char_in == 8'h2d)
			cls = CC_SIGN;
		else if (char_in == 8'h24)
			cls = CC_DOLLAR;
		else if (char_in == 8'h23)
			cls = CC_HASH;
		else if (char_in == 8'h2e)
			cls = CC_DOT;
		else if ((char_in >= 8'h41 && char_in <= 8'h5a) ||
				(char_in >= 8'h61 && char_in <= 8'h7a) || char_in == 8'h5f)
			cls = CC_NAME;
		else
			cls = CC_OTHER;
	end

	assign in_stall = valid_s1 & q_full;
	assign push = valid_s1 & ~q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.ch <= char_in;
			item_s1.last <= last_byte;
			item_s1.cls <= cls;
		end
	end

endmodule

FILE: design/srft_queue.sv
// short request queue between the front end and the back end
// depends on srft_pkg
module srft_queue import srft_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  srft_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       q_valid,
	output srft_item_t q_item
);

	srft_item_t         mem_q [QDEPTH];
	logic [QAW-1:0]     wr_q;
	logic [QAW-1:0]     rd_q;
	logic [QAW:0]       cnt_q;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

FILE: design/srft_back.sv
// back end: quote, escape and depth tracking, element classifier, result register
// depends on srft_pkg
module srft_back import srft_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  srft_item_t  q_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        char_valid,
	output logic [7:0]  decoded_char,
	output logic        element_end,
	output logic [3:0]  list_level,
	output logic [3:0]  element_kind,
	output logic [31:0] element_value,
	output logic [2:0]  error_code
);

	logic               in_quote_q, esc_q, neg_q, gap_q, fother_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [3:0]         tclass_q;
	logic [31:0]        acc_q;
	logic [7:0]         tlen_q, lastns_q;

	logic               n_in_quote, n_esc, n_neg, n_gap, n_fother;
	logic [DEPTH_W-1:0] n_depth;
	logic [3:0]         n_tclass;
	logic [31:0]        n_acc;
	logic [7:0]         n_tlen, n_lastns;

	logic        r_cv, r_end;
	logic [7:0]  r_dch;
	logic [3:0]  r_lvl, r_kind;
	logic [31:0] r_val;
	logic [2:0]  r_err;
	logic        ended, shallow;
	srft_fin_t   fin;
	logic [7:0]  ch;
	logic [3:0]  cls;

	logic        out_valid_q;

	function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [3:0] d);
		logic [35:0] t;
		begin
			t = {4'b0, acc} * 36'd10 + {32'b0, d};
			if (t > {4'b0, ACC_LIMIT})
				return ACC_STICKY;
			return t[31:0];
		end
	endfunction

	function automatic srft_fin_t finish(input logic [3:0] tc, input logic [31:0] acc,
			input logic neg);
		srft_fin_t  f;
		logic [31:0] lim;
		begin
			f.kind = kind_of(tc);
			f.value = '0;
			f.ovf = 1'b0;
			if (tc == TC_INT || tc == TC_REF) begin
				lim = (tc == TC_INT && neg) ? ACC_LIMIT : POS_LIMIT;
				if (acc > lim)
					f.ovf = 1'b1;
				else if (tc == TC_INT && neg)
					f.value = 32'd0 - acc;
				else
					f.value = acc;
			end
			return f;
		end
	endfunction

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		begin
			return (v != 8'hff) ? v + 8'd1 : v;
		end
	endfunction

	assign pop = q_valid & (~out_valid_q | ~out_stall);
	assign ch = q_item.ch;
	assign cls = q_item.cls;
	assign shallow = (depth_q <= DEPTH_W'(1));

	always_comb begin
		n_in_quote = in_quote_q;
		n_esc = esc_q;
		n_neg = neg_q;
		n_gap = gap_q;
		n_fother = fother_q;
		n_depth = depth_q;
		n_tclass = tclass_q;
		n_acc = acc_q;
		n_tlen = tlen_q;
		n_lastns = lastns_q;
		r_cv = 1'b0;
		r_dch = 8'd0;
		r_end = 1'b0;
		r_lvl = 4'd0;
		r_kind = 4'd0;
		r_val = 32'd0;
		r_err = ERR_NONE;
		ended = 1'b0;
		fin = finish(tclass_q, acc_q, neg_q);

		if (in_quote_q) begin
			if (esc_q) begin
				n_esc = 1'b0;
				if (cls == CC_QUOTE || cls == CC_BSLASH) begin
					r_cv = 1'b1;
					r_dch = ch;
				end else if (ch == 8'h6e) begin
					r_cv = 1'b1;
					r_dch = 8'h0a;
				end else if (ch == 8'h72) begin
					r_cv = 1'b1;
					r_dch = 8'h0d;
				end else begin
					r_err = raise_err(r_err, ERR_ESCAPE);
					n_tclass = TC_OTHER;
				end
			end else if (cls == CC_BSLASH) begin
				n_esc = 1'b1;
			end else if (cls == CC_QUOTE) begin
				n_in_quote = 1'b0;
			end else begin
				r_cv = 1'b1;
				r_dch = ch;
			end
		end else if (cls == CC_SPACE) begin
			if (shallow && tlen_q != 8'd0)
				n_gap = 1'b1;
		end else if (cls == CC_QUOTE) begin
			n_in_quote = 1'b1;
			if (shallow) begin
				n_tclass = (tlen_q == 8'd0) ? TC_STR : TC_OTHER;
				n_tlen = sat_inc(tlen_q);
				n_lastns = ch;
			end
		end else if (cls == CC_LPAREN) begin
			if (depth_q == '0) begin
				n_fother = (tlen_q != 8'd0);
				n_tclass = TC_EMPTY;
				n_acc = '0;
				n_neg = 1'b0;
				n_tlen = '0;
				n_lastns = '0;
				n_gap = 1'b0;
				n_depth = DEPTH_W'(1);
			end else if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
				r_err = raise_err(r_err, ERR_PAREN);
				n_tclass = TC_OTHER;
				if (depth_q == DEPTH_W'(1)) begin
					n_tlen = sat_inc(tlen_q);
					n_lastns = ch;
				end
			end else if (depth_q == DEPTH_W'(1)) begin
				n_tclass = (tlen_q == 8'd0) ? TC_LIST : TC_OTHER;
				n_tlen = sat_inc(tlen_q);
				n_lastns = ch;
				n_depth = DEPTH_W'(2);
			end else begin
				n_depth = depth_q + 1'b1;
			end
		end else if (cls == CC_RPAREN) begin
			if (depth_q == '0) begin
				r_err = raise_err(r_err, ERR_PAREN);
				n_tclass = TC_OTHER;
				n_tlen = sat_inc(tlen_q);
				n_lastns = ch;
			end else if (depth_q == DEPTH_W'(1)) begin
				if (tlen_q != 8'd0) begin
					r_end = 1'b1;
					r_lvl = 4'd1;
					r_kind = fin.kind;
					r_val = fin.value;
					if (fin.ovf)
						r_err = raise_err(r_err, ERR_OVERFLOW);
					ended = 1'b1;
				end
				n_tclass = fother_q ? TC_OTHER : TC_LIST;
				n_acc = '0;
				n_neg = 1'b0;
				n_tlen = 8'd1;
				n_lastns = ch;
				n_gap = 1'b0;
				n_fother = 1'b0;
				n_depth = '0;
			end else begin
				n_depth = depth_q - 1'b1;
			end
		end else if (cls == CC_COMMA) begin
			if (shallow) begin
				r_end = 1'b1;
				r_lvl = 4'(depth_q);
				r_kind = fin.kind;
				r_val = fin.value;
				if (fin.ovf)
					r_err = raise_err(r_err, ERR_OVERFLOW);
				ended = 1'b1;
				n_tclass = TC_EMPTY;
				n_acc = '0;
				n_neg = 1'b0;
				n_tlen = '0;
				n_lastns = '0;
				n_gap = 1'b0;
				if (depth_q == '0)
					n_fother = 1'b0;
			end
		end else if (shallow) begin
			if (gap_q) begin
				n_tclass = TC_OTHER;
			end else begin
				case (tclass_q)
					TC_EMPTY: begin
						if (cls == CC_DOLLAR)
							n_tclass = TC_DOLLAR;
						else if (cls == CC_SIGN) begin
							n_tclass = TC_SIGN;
							n_neg = (ch == 8'h2d);
						end else if (cls == CC_DIGIT) begin
							n_tclass = TC_INT;
							n_acc = add_digit(acc_q, ch[3:0]);
						end else if (cls == CC_HASH)
							n_tclass = TC_HASH;
						else if (cls == CC_DOT)
							n_tclass = TC_DOT;
						else
							n_tclass = TC_OTHER;
					end
					TC_SIGN, TC_INT: begin
						if (cls == CC_DIGIT) begin
							n_tclass = TC_INT;
							n_acc = add_digit(acc_q, ch[3:0]);
						end else
							n_tclass = TC_OTHER;
					end
					TC_HASH, TC_REF: begin
						if (cls == CC_DIGIT) begin
							n_tclass = TC_REF;
							n_acc = add_digit(acc_q, ch[3:0]);
						end else
							n_tclass = TC_OTHER;
					end
					TC_DOT: begin
						if (cls == CC_DOT) begin
							if (tlen_q == 8'd2 && lastns_q == 8'h54)
								n_tclass = TC_TRUE;
							else if (tlen_q == 8'd2 && lastns_q == 8'h46)
								n_tclass = TC_FALSE;
							else if (tlen_q >= 8'd2)
								n_tclass = TC_ENUM;
							else
								n_tclass = TC_OTHER;
						end else if (cls != CC_DIGIT && cls != CC_NAME) begin
							n_tclass = TC_OTHER;
						end
					end
					default: n_tclass = TC_OTHER;
				endcase
			end
			n_tlen = sat_inc(tlen_q);
			n_lastns = ch;
		end

		if (q_item.last) begin
			if (!ended) begin
				r_end = 1'b1;
				r_lvl = 4'd0;
				if (n_depth != '0) begin
					r_kind = n_fother ? K_OTHER : K_LIST;
					r_val = '0;
					r_err = raise_err(r_err, ERR_PAREN);
				end else begin
					fin = finish(n_tclass, n_acc, n_neg);
					r_kind = fin.kind;
					r_val = fin.value;
					if (fin.ovf)
						r_err = raise_err(r_err, ERR_OVERFLOW);
				end
				if (n_in_quote)
					r_err = raise_err(r_err, ERR_OPEN_STR);
			end
			n_in_quote = 1'b0;
			n_esc = 1'b0;
			n_depth = '0;
			n_fother = 1'b0;
			n_tclass = TC_EMPTY;
			n_acc = '0;
			n_neg = 1'b0;
			n_tlen = '0;
			n_lastns = '0;
			n_gap = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q <= 1'b0;
			esc_q <= 1'b0;
			neg_q <= 1'b0;
			gap_q <= 1'b0;
			fother_q <= 1'b0;
			depth_q <= '0;
			tclass_q <= TC_EMPTY;
			acc_q <= '0;
			tlen_q <= '0;
			lastns_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				in_quote_q <= n_in_quote;
				esc_q <= n_esc;
				neg_q <= n_neg;
				gap_q <= n_gap;
				fother_q <= n_fother;
				depth_q <= n_depth;
				tclass_q <= n_tclass;
				acc_q <= n_acc;
				tlen_q <= n_tlen;
				lastns_q <= n_lastns;
			end
			if (!out_valid_q || !out_stall)
				out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			char_valid <= r_cv;
			decoded_char <= r_dch;
			element_end <= r_end;
			list_level <= r_lvl;
			element_kind <= r_kind;
			element_value <= r_val;
			error_code <= r_err;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/step_record_field_tokenizer.sv
// top level of the step record field tokenizer
// depends on srft_pkg, srft_front, srft_queue, srft_back
//
// one byte of an entity record's argument list enters per request on the
// input channel (in_valid / in_stall), last_byte marking the record's final
// byte. every byte gives exactly one result request on the output channel
// (out_valid / out_stall): a decoded string byte, an element end with its
// kind and value, and an error code.
// throughput is one byte per cycle while out_stall is low, set by the state
// update of the back end. a result passes the front register, the queue and
// the result register before it shows on out_valid.
// the front end registers and classifies bytes and feeds a four-entry
// queue; the back end drains it into a result register. when out_stall is
// held the result holds, the queue fills, and in_stall rises once the
// queue and the front register are full.
// reset empties the queue, clears out_valid and all tokenizer state; a
// record may start on the first cycle after reset. last_byte also returns
// the tokenizer state to its reset value.
module step_record_field_tokenizer import srft_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        char_valid,
	output logic [7:0]  decoded_char,
	output logic        element_end,
	output logic [3:0]  list_level,
	output logic [3:0]  element_kind,
	output logic signed [31:0] element_value,
	output logic [2:0]  error_code
);

	logic       q_full, push, pop, q_valid;
	srft_item_t push_item, q_item;
	logic [31:0] value_raw;

	srft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	srft_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	srft_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.char_valid    (char_valid),
		.decoded_char  (decoded_char),
		.element_end   (element_end),
		.list_level    (list_level),
		.element_kind  (element_kind),
		.element_value (value_raw),
		.error_code    (error_code)
	);

	assign element_value = signed'(value_raw);

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for step_record_field_tokenizer: directed and random records,
// a byte-level predictor in a scoreboard class, random idling on both channels
// depends on srft_pkg and the tokenizer rtl

module testbench import srft_pkg::*;;

	typedef struct {
		bit        char_valid;
		bit [7:0]  decoded_char;
		bit        element_end;
		bit [3:0]  list_level;
		bit [3:0]  element_kind;
		bit [31:0] element_value;
		bit [2:0]  error_code;
	} token_result_t;

	class tokenizer_scoreboard;
		token_result_t token_results_q[$];
		token_result_t outcome;
		int errors;
		bit in_quote;
		bit escape_pending;
		bit gap_seen;
		bit field_other;
		bit negative;
		int depth;
		int tlen;
		bit [3:0] tclass;
		bit [7:0] last_ns;
		longint unsigned accum;

		function new();
			errors = 0;
			reset_record();
		endfunction

		function void clear_element();
			tclass = TC_EMPTY;
			accum = 0;
			negative = 0;
			tlen = 0;
			last_ns = 0;
			gap_seen = 0;
		endfunction

		function void reset_record();
			in_quote = 0;
			escape_pending = 0;
			depth = 0;
			field_other = 0;
			clear_element();
		endfunction

		function void flag_error(bit [2:0] code);
			if (outcome.error_code == ERR_NONE || code < outcome.error_code)
				outcome.error_code = code;
		endfunction

		function void count_byte(bit [7:0] c);
			if (tlen < 255)
				tlen++;
			last_ns = c;
		endfunction

		function void add_digit(bit [7:0] c);
			accum = accum * 10 + (c - 8'd48);
			// sticky once past 2^31
			if (accum > 64'h8000_0000)
				accum = 64'h8000_0001;
		endfunction

		function bit is_digit(bit [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_name(bit [7:0] c);
			return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
		endfunction

		function bit [3:0] kind_for(bit [3:0] tc);
			case (tc)
				TC_DOLLAR: return K_UNSET;
				TC_INT:    return K_INT;
				TC_REF:    return K_REF;
				TC_TRUE:   return K_TRUE;
				TC_FALSE:  return K_FALSE;
				TC_ENUM:   return K_ENUM;
				TC_STR:    return K_STR;
				TC_LIST:   return K_LIST;
				default:   return K_OTHER;
			endcase
		endfunction

		function void end_element(int lvl);
			longint unsigned lim;
			outcome.element_end = 1;
			outcome.list_level = 4'(lvl);
			outcome.element_kind = kind_for(tclass);
			outcome.element_value = 0;
			if (tclass == TC_INT || tclass == TC_REF) begin
				lim = (tclass == TC_INT && negative) ? 64'h8000_0000 : 64'h7fff_ffff;
				if (accum > lim)
					flag_error(ERR_OVERFLOW);
				else if (tclass == TC_INT && negative)
					outcome.element_value = -accum[31:0];
				else
					outcome.element_value = accum[31:0];
			end
		endfunction

		function void advance_element(bit [7:0] c);
			bit [3:0] k;
			k = tclass;
			if (gap_seen) begin
				k = TC_OTHER;
			end else begin
				case (k)
					TC_EMPTY: begin
						if (c == "$") begin
							k = TC_DOLLAR;
						end else if (c == "+" || c == "-") begin
							k = TC_SIGN;
							negative = (c == "-");
						end else if (is_digit(c)) begin
							k = TC_INT;
							add_digit(c);
						end else if (c == "#") begin
							k = TC_HASH;
						end else if (c == ".") begin
							k = TC_DOT;
						end else begin
							k = TC_OTHER;
						end
					end
					TC_SIGN, TC_INT: begin
						if (is_digit(c)) begin
							k = TC_INT;
							add_digit(c);
						end else begin
							k = TC_OTHER;
						end
					end
					TC_HASH, TC_REF: begin
						if (is_digit(c)) begin
							k = TC_REF;
							add_digit(c);
						end else begin
							k = TC_OTHER;
						end
					end
					TC_DOT: begin
						if (c == ".") begin
							if (tlen == 2 && last_ns == "T")
								k = TC_TRUE;
							else if (tlen == 2 && last_ns == "F")
								k = TC_FALSE;
							else if (tlen >= 2)
								k = TC_ENUM;
							else
								k = TC_OTHER;
						end else if (!is_name(c)) begin
							k = TC_OTHER;
						end
					end
					default: k = TC_OTHER;
				endcase
			end
			tclass = k;
			count_byte(c);
		endfunction

		function void take_byte(bit [7:0] c, bit last);
			bit ended;
			outcome = '{default: 0};
			ended = 0;
			if (in_quote) begin
				if (escape_pending) begin
					escape_pending = 0;
					if (c == "'" || c == "\\") begin
						outcome.char_valid = 1;
						outcome.decoded_char = c;
					end else if (c == "n") begin
						outcome.char_valid = 1;
						outcome.decoded_char = 8'h0a;
					end else if (c == "r") begin
						outcome.char_valid = 1;
						outcome.decoded_char = 8'h0d;
					end else begin
						flag_error(ERR_ESCAPE);
						tclass = TC_OTHER;
					end
				end else if (c == "\\") begin
					escape_pending = 1;
				end else if (c == "'") begin
					in_quote = 0;
				end else begin
					outcome.char_valid = 1;
					outcome.decoded_char = c;
				end
			end else if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
				if (depth <= 1 && tlen > 0)
					gap_seen = 1;
			end else if (c == "'") begin
				in_quote = 1;
				if (depth <= 1) begin
					tclass = (tlen == 0) ? TC_STR : TC_OTHER;
					count_byte(c);
				end
			end else if (c == "(") begin
				if (depth == 0) begin
					field_other = (tlen != 0);
					clear_element();
					depth = 1;
				end else if (depth >= MAX_DEPTH) begin
					flag_error(ERR_PAREN);
					tclass = TC_OTHER;
					if (depth == 1)
						count_byte(c);
				end else if (depth == 1) begin
					tclass = (tlen == 0) ? TC_LIST : TC_OTHER;
					count_byte(c);
					depth = 2;
				end else begin
					depth++;
				end
			end else if (c == ")") begin
				if (depth == 0) begin
					flag_error(ERR_PAREN);
					tclass = TC_OTHER;
					count_byte(c);
				end else if (depth == 1) begin
					if (tlen > 0) begin
						end_element(1);
						ended = 1;
					end
					clear_element();
					tclass = field_other ? TC_OTHER : TC_LIST;
					tlen = 1;
					last_ns = c;
					field_other = 0;
					depth = 0;
				end else begin
					depth--;
				end
			end else if (c == ",") begin
				if (depth <= 1) begin
					end_element(depth);
					ended = 1;
					clear_element();
					if (depth == 0)
						field_other = 0;
				end
			end else if (depth <= 1) begin
				advance_element(c);
			end

			if (last) begin
				if (!ended) begin
					if (depth > 0) begin
						outcome.element_end = 1;
						outcome.list_level = 0;
						outcome.element_kind = field_other ? K_OTHER : K_LIST;
						outcome.element_value = 0;
						flag_error(ERR_PAREN);
					end else begin
						end_element(0);
					end
					if (in_quote)
						flag_error(ERR_OPEN_STR);
				end
				reset_record();
			end
			token_results_q.insert(token_results_q.size(), outcome);
		endfunction

		function void compare_field(string name, bit [31:0] want, bit [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_token(token_result_t got);
			token_result_t want;
			if (token_results_q.size() == 0) begin
				errors++;
				$display("%0t: result request with no pending prediction", $time);
				return;
			end
			want = token_results_q.pop_front();
			compare_field("char_valid", want.char_valid, got.char_valid);
			compare_field("decoded_char", want.decoded_char, got.decoded_char);
			compare_field("element_end", want.element_end, got.element_end);
			compare_field("list_level", want.list_level, got.list_level);
			compare_field("element_kind", want.element_kind, got.element_kind);
			compare_field("element_value", want.element_value, got.element_value);
			compare_field("error_code", want.error_code, got.error_code);
		endfunction
	endclass

	localparam string NOISE_SET = "()',\\ $#.+-0T9aF_\t";
	localparam string NAME_SET = "ABZaz09_T";
	localparam string ESC_SET = "'nr\\";
	localparam string SPACE_SET = " \t\r\n";
	localparam string INT_EDGES[6] = '{"2147483647", "2147483648", "-2147483648",
		"-2147483649", "+0", "4294967295"};
	localparam string REF_EDGES[4] = '{"2147483647", "2147483648", "0", "42949672950"};
	localparam string OTHER_TEXT[6] = '{"1.5", "-0.2E3", "IFCX(3)", "a b", "*", "1e"};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_in;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic        char_valid;
	logic [7:0]  decoded_char;
	logic        element_end;
	logic [3:0]  list_level;
	logic [3:0]  element_kind;
	logic signed [31:0] element_value;
	logic [2:0]  error_code;

	tokenizer_scoreboard sb = new();
	bit [7:0] record_bytes[$];
	int idle_mode;

	step_record_field_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_valid(char_valid),
		.decoded_char(decoded_char),
		.element_end(element_end),
		.list_level(list_level),
		.element_kind(element_kind),
		.element_value(element_value),
		.error_code(error_code)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		case (idle_mode)
			0: return 0;
			1: return (pick < 25) ? $urandom_range(1, 2) : 0;
			default: begin
				if (pick < 55)
					return 0;
				if (pick < 90)
					return $urandom_range(1, 4);
				return $urandom_range(10, 40);
			end
		endcase
	endfunction

	function automatic void put_byte(bit [7:0] b);
		record_bytes.insert(record_bytes.size(), b);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic bit [7:0] noise_byte();
		if ($urandom_range(0, 1))
			return NOISE_SET[$urandom_range(0, NOISE_SET.len() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_number(bit is_ref);
		if ($urandom_range(0, 7) == 0) begin
			if (is_ref)
				put_text(REF_EDGES[$urandom_range(0, 3)]);
			else
				put_text(INT_EDGES[$urandom_range(0, 5)]);
		end else begin
			if (!is_ref && $urandom_range(0, 2) == 0)
				put_byte($urandom_range(0, 1) ? "-" : "+");
			repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 12 : 3))
				put_byte(8'($urandom_range(48, 57)));
		end
	endfunction

	function automatic void put_quoted();
		int pick;
		bit [7:0] b;
		put_byte("'");
		repeat ($urandom_range(0, 6)) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				b = 8'($urandom_range(0, 255));
				if (b == "'" || b == "\\")
					b = "a";
				put_byte(b);
			end else if (pick < 94) begin
				put_byte("\\");
				put_byte(ESC_SET[$urandom_range(0, 3)]);
			end else begin
				b = 8'($urandom_range(0, 255));
				if (b == "'" || b == "\\" || b == "n" || b == "r")
					b = "x";
				put_byte("\\");
				put_byte(b);
			end
		end
		put_byte("'");
	endfunction

	function automatic void put_element(int lvl);
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 7) == 0)
			put_byte(SPACE_SET[$urandom_range(0, 3)]);
		if (pick < 10) begin
			put_byte("$");
		end else if (pick < 32) begin
			put_number(0);
		end else if (pick < 46) begin
			put_byte("#");
			put_number(1);
		end else if (pick < 60) begin
			put_byte(".");
			case ($urandom_range(0, 3))
				0: put_byte("T");
				1: put_byte("F");
				default: repeat ($urandom_range(0, 4))
					put_byte(NAME_SET[$urandom_range(0, NAME_SET.len() - 1)]);
			endcase
			put_byte(".");
		end else if (pick < 78) begin
			put_quoted();
		end else if (pick < 90 && lvl < 4) begin
			put_byte("(");
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				if (i > 0)
					put_byte(",");
				put_element(lvl + 1);
			end
			put_byte(")");
		end else begin
			put_text(OTHER_TEXT[$urandom_range(0, 5)]);
		end
		if ($urandom_range(0, 7) == 0)
			put_byte(SPACE_SET[$urandom_range(0, 3)]);
	endfunction

	function automatic void build_record();
		int nf;
		record_bytes.delete();
		case ($urandom_range(0, 9))
			0: repeat ($urandom_range(1, 12))
				put_byte(noise_byte());
			1: begin
				repeat ($urandom_range(13, 17))
					put_byte("(");
				put_element(1);
			end
			default: begin
				nf = $urandom_range(1, 5);
				for (int i = 0; i < nf; i++) begin
					if (i > 0)
						put_byte(",");
					put_element(0);
				end
				if ($urandom_range(0, 9) == 0)
					put_byte(",");
				if ($urandom_range(0, 7) == 0)
					record_bytes.insert($urandom_range(0, record_bytes.size()), noise_byte());
			end
		endcase
	endfunction

	task automatic send_byte(bit [7:0] c, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		last_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_record();
		int pick;
		pick = $urandom_range(0, 9);
		idle_mode = (pick < 3) ? 0 : (pick < 7) ? 1 : 2;
		foreach (record_bytes[i])
			send_byte(record_bytes[i], i == record_bytes.size() - 1);
	endtask

	task automatic send_text(string s);
		record_bytes.delete();
		put_text(s);
		send_record();
	endtask

	// accepted bytes feed the predictor, accepted results are checked
	always @(posedge clk) begin
		token_result_t seen;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_byte(char_in, last_byte);
			if (out_valid && !out_stall) begin
				seen.char_valid = char_valid;
				seen.decoded_char = decoded_char;
				seen.element_end = element_end;
				seen.list_level = list_level;
				seen.element_kind = element_kind;
				seen.element_value = element_value;
				seen.error_code = error_code;
				sb.check_token(seen);
			end
		end
	end

	initial begin
		int gap;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int sent;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_in <= 8'h00;
		last_byte <= 1'b0;
		idle_mode = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// kinds, escapes, nesting, overflow, bad close, too deep, open string
		send_text("$,+7,#12,.T.,.F.,.E_1.,..,'a''b',1 2");
		send_text("('\\'\\\\\\n\\r\\z',(#3,()),-2147483648),()");
		send_text("2147483648,#2147483648,x(1),)");
		send_text("((((((((((((((((1'");
		send_text("(5)");
		send_text("7,");
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);

		sent = 0;
		while (sent < 700) begin
			build_record();
			sent += record_bytes.size();
			send_record();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.token_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
